/* hw/rtl/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Field widths, action and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned ACT_W = 3;
  localparam int unsigned POS_W = 7;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND,
    ACT_PREPEND,
    ACT_INSERT,
    ACT_RM_LAST,
    ACT_RM_FIRST,
    ACT_RM_AT,
    ACT_REVERSE,
    ACT_READ
  } act_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_RANGE
  } st_e;

  // What an accepted item needs from the store
  typedef enum logic [2:0] {
    JOB_NONE,
    JOB_DROP,
    JOB_READ,
    JOB_UP,
    JOB_DOWN,
    JOB_REV
  } job_e;

  // Read and pointer step issued to the datapath in one cycle
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_UP,
    STEP_DOWN,
    STEP_REV_A,
    STEP_REV_B,
    STEP_READ
  } step_e;

  // Write port source; the address follows the source
  typedef enum logic [1:0] {
    WSEL_RD,
    WSEL_HOLD,
    WSEL_VAL
  } wsel_e;

  typedef struct packed {
    logic  load;
    step_e step;
    logic  wr_en;
    wsel_e wr_sel;
    logic  cnt_inc;
    logic  cnt_dec;
    logic  res_ld;
  } cmd_t;

  typedef struct packed {
    job_e job;
    logic up_more;
    logic down_more;
    logic rev_more;
  } sts_t;

endpackage

/* hw/rtl/ple_datapath.sv */
// ----------------------------------------------------------------------------
// ple_datapath: element store, pointers and result registers
// Decodes an item on transfer, then moves elements through a single-port
// read / single-port write store as the controller steps it.
// ----------------------------------------------------------------------------
module ple_datapath #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ple_pkg::cmd_t                cmd_i,
  output ple_pkg::sts_t                sts_o,
  input  logic [ple_pkg::ACT_W-1:0]    action_i,
  input  logic [ple_pkg::POS_W-1:0]    position_i,
  input  logic [ple_pkg::VAL_W-1:0]    value_i,
  output logic [ple_pkg::VAL_W-1:0]    read_value_o,
  output logic [ple_pkg::LEN_W-1:0]    list_length_o,
  output logic [ple_pkg::ST_W-1:0]     status_o
);
  import ple_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned MW = (ELEM_WIDTH > VAL_W) ? ELEM_WIDTH : VAL_W;

  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         lo_q, hi_q, at_q;
  logic [CW-1:0]         lo_p1, hi_m1;
  logic [AW-1:0]         wa_q, wb_q;
  job_e                  job_q;
  st_e                   code_q;
  logic [ELEM_WIDTH-1:0] val_q, rd_q, hold_q;
  logic [ELEM_WIDTH-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0]      rv_q;
  logic [LEN_W-1:0]      len_q;
  st_e                   st_q;

  // decode at transfer
  logic [XW-1:0] pos_x, cnt_x, len_x;
  logic [MW-1:0] val_x, rv_x;
  logic          full, empty;
  job_e          job_d;
  st_e           code_d;
  logic [CW-1:0] at_d;

  // store ports
  logic                  re, we;
  logic [AW-1:0]         raddr, waddr;
  logic [ELEM_WIDTH-1:0] wdata;

  always_comb begin
    pos_x  = XW'(position_i);
    cnt_x  = XW'(cnt_q);
    full   = (cnt_q == CW'(DEPTH));
    empty  = (cnt_q == '0);
    job_d  = JOB_NONE;
    code_d = ST_OK;
    at_d   = '0;
    case (act_e'(action_i))
      ACT_APPEND: begin
        if (full) code_d = ST_FULL;
        else begin
          job_d = JOB_UP;
          at_d  = cnt_q;
        end
      end
      ACT_PREPEND: begin
        if (full) code_d = ST_FULL;
        else job_d = JOB_UP;
      end
      ACT_INSERT: begin
        if (pos_x > cnt_x) code_d = ST_RANGE;
        else if (full) code_d = ST_FULL;
        else begin
          job_d = JOB_UP;
          at_d  = pos_x[CW-1:0];
        end
      end
      ACT_RM_LAST: begin
        if (empty) code_d = ST_EMPTY;
        else job_d = JOB_DROP;
      end
      ACT_RM_FIRST: begin
        if (empty) code_d = ST_EMPTY;
        else job_d = JOB_DOWN;
      end
      ACT_RM_AT: begin
        if (empty) code_d = ST_EMPTY;
        else if (pos_x >= cnt_x) code_d = ST_RANGE;
        else begin
          job_d = JOB_DOWN;
          at_d  = pos_x[CW-1:0];
        end
      end
      ACT_REVERSE: job_d = JOB_REV;
      ACT_READ: begin
        if (pos_x >= cnt_x) code_d = ST_RANGE;
        else begin
          job_d = JOB_READ;
          at_d  = pos_x[CW-1:0];
        end
      end
      default: job_d = JOB_NONE;
    endcase
  end

  assign lo_p1 = lo_q + CW'(1);
  assign hi_m1 = hi_q - CW'(1);

  assign sts_o.job       = job_q;
  assign sts_o.up_more   = (hi_q > at_q);
  assign sts_o.down_more = (lo_p1 < cnt_q);
  assign sts_o.rev_more  = (lo_p1 < hi_q);

  always_comb begin
    re    = (cmd_i.step != STEP_NONE);
    raddr = '0;
    case (cmd_i.step)
      STEP_UP:    raddr = hi_m1[AW-1:0];
      STEP_DOWN:  raddr = lo_p1[AW-1:0];
      STEP_REV_A: raddr = lo_q[AW-1:0];
      STEP_REV_B: raddr = hi_m1[AW-1:0];
      STEP_READ:  raddr = at_q[AW-1:0];
      default:    raddr = '0;
    endcase
  end

  always_comb begin
    we = cmd_i.wr_en;
    case (cmd_i.wr_sel)
      WSEL_RD: begin
        waddr = wa_q;
        wdata = rd_q;
      end
      WSEL_HOLD: begin
        waddr = wb_q;
        wdata = hold_q;
      end
      WSEL_VAL: begin
        waddr = at_q[AW-1:0];
        wdata = val_q;
      end
      default: begin
        waddr = wa_q;
        wdata = rd_q;
      end
    endcase
  end

  // element store, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rd_q <= mem_q[raddr];
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) cnt_d = cnt_q + CW'(1);
    else if (cmd_i.cnt_dec) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign val_x = MW'(value_i);
  assign rv_x  = MW'(rd_q);
  assign len_x = XW'(cnt_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q  <= val_x[ELEM_WIDTH-1:0];
      at_q   <= at_d;
      lo_q   <= at_d;
      hi_q   <= cnt_q;
      job_q  <= job_d;
      code_q <= code_d;
    end
    case (cmd_i.step)
      STEP_UP: begin
        wa_q <= hi_q[AW-1:0];
        hi_q <= hi_m1;
      end
      STEP_DOWN: begin
        wa_q <= lo_q[AW-1:0];
        lo_q <= lo_p1;
      end
      STEP_REV_A: wa_q <= lo_q[AW-1:0];
      STEP_REV_B: begin
        wb_q   <= hi_m1[AW-1:0];
        hold_q <= rd_q;
        hi_q   <= hi_m1;
        lo_q   <= lo_p1;
      end
      default: ;
    endcase
    if (cmd_i.res_ld) begin
      rv_q  <= (job_q == JOB_READ) ? rv_x[VAL_W-1:0] : '0;
      len_q <= len_x[LEN_W-1:0];
      st_q  <= code_q;
    end
  end

  assign read_value_o  = rv_q;
  assign list_length_o = len_q;
  assign status_o      = st_q;

endmodule

/* hw/rtl/ple_ctrl.sv */
// ----------------------------------------------------------------------------
// ple_ctrl: sequencer of the positional list engine
// Takes one item, steps the datapath through the shift, swap or read it
// needs, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ple_pkg::sts_t sts_i,
  output ple_pkg::cmd_t cmd_o
);
  import ple_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_UP,
    S_PUT,
    S_DOWN,
    S_REV_A,
    S_REV_B,
    S_REV_TAIL,
    S_RD_WAIT,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;  // a read is in flight and its write is owed

  always_comb begin
    state_d       = state_q;
    pend_d        = pend_q;
    cmd_o         = '0;
    cmd_o.step    = STEP_NONE;
    cmd_o.wr_sel  = WSEL_RD;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pend_d     = 1'b0;
          state_d    = S_START;
        end
      end
      S_START: begin
        case (sts_i.job)
          JOB_DROP: begin
            cmd_o.cnt_dec = 1'b1;
            cmd_o.res_ld  = 1'b1;
            state_d       = S_RESP;
          end
          JOB_READ: begin
            cmd_o.step = STEP_READ;
            state_d    = S_RD_WAIT;
          end
          JOB_UP:   state_d = S_UP;
          JOB_DOWN: state_d = S_DOWN;
          JOB_REV:  state_d = S_REV_A;
          default: begin
            cmd_o.res_ld = 1'b1;
            state_d      = S_RESP;
          end
        endcase
      end
      S_UP: begin
        cmd_o.wr_en = pend_q;
        if (sts_i.up_more) begin
          cmd_o.step = STEP_UP;
          pend_d     = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WSEL_VAL;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.res_ld  = 1'b1;
        state_d       = S_RESP;
      end
      S_DOWN: begin
        cmd_o.wr_en = pend_q;
        if (sts_i.down_more) begin
          cmd_o.step = STEP_DOWN;
          pend_d     = 1'b1;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.res_ld  = 1'b1;
          pend_d        = 1'b0;
          state_d       = S_RESP;
        end
      end
      S_REV_A: begin
        cmd_o.wr_en = pend_q;
        if (sts_i.rev_more) begin
          cmd_o.step = STEP_REV_A;
          state_d    = S_REV_B;
        end else if (pend_q) begin
          state_d = S_REV_TAIL;
        end else begin
          cmd_o.res_ld = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_REV_B: begin
        cmd_o.step   = STEP_REV_B;
        cmd_o.wr_en  = pend_q;
        cmd_o.wr_sel = WSEL_HOLD;
        pend_d       = 1'b1;
        state_d      = S_REV_A;
      end
      S_REV_TAIL: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WSEL_HOLD;
        cmd_o.res_ld = 1'b1;
        pend_d       = 1'b0;
        state_d      = S_RESP;
      end
      S_RD_WAIT: begin
        cmd_o.res_ld = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);

endmodule

/* hw/rtl/positional_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// positional_list_engine_unit: ordered list in a fixed element store
//
//   Channel  Direction  Handshake              Payload
//   in       sink       in_valid_i/in_ready_o  action_i, position_i, value_i
//   out      source     out_valid_o/out_ready_i read_value_o, list_length_o,
//                                               status_o
//
// One item in flight. Each moved element is one read and one write at the
// single read and single write port of the store, overlapped.
// in_ready_o is low from the input transfer until the result is taken.
// Reset clears the length and the sequencer only; store contents are
// never cleared, entries beyond the length are never read.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ple_pkg::ACT_W-1:0] action_i,
  input  logic [ple_pkg::POS_W-1:0] position_i,
  input  logic [ple_pkg::VAL_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ple_pkg::VAL_W-1:0] read_value_o,
  output logic [ple_pkg::LEN_W-1:0] list_length_o,
  output logic [ple_pkg::ST_W-1:0]  status_o
);
  import ple_pkg::*;

  // controller -> datapath commands, datapath -> controller status
  cmd_t cmd;
  sts_t sts;

  // Sequencer: decides per cycle which read, write and pointer step the
  // store performs. Shifts are pipelined, a read at one address and the
  // write of the previous read in the same cycle.
  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Store, length count, pointers and result registers. The item is
  // decoded and checked at the input transfer; the status code is known
  // before any element moves.
  ple_datapath #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .read_value_o  (read_value_o),
    .list_length_o (list_length_o),
    .status_o      (status_o)
  );

endmodule

/* hw/rtl/ple_checker.sv */
// ----------------------------------------------------------------------------
// ple_checker: port-level checks of the positional list engine
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module ple_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [ple_pkg::VAL_W-1:0] read_value_o,
  input logic [ple_pkg::LEN_W-1:0] list_length_o,
  input logic [ple_pkg::ST_W-1:0]  status_o
);
  import ple_pkg::*;

  // one item at a time: busy after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // a result is never shown twice
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("result repeated after its transfer");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result waits");

  // a dropped insert reports a full list
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (list_length_o == LEN_W'(DEPTH)))
    else $error("full status with a length other than capacity");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o)
      && $stable(list_length_o) && $stable(status_o))
    else $error("stalled result changed");

endmodule

bind positional_list_engine_unit ple_checker #(
  .DEPTH (DEPTH)
) u_ple_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .read_value_o  (read_value_o),
  .list_length_o (list_length_o),
  .status_o      (status_o)
);

/* bench/positional_list_engine_unit_tb.sv */
// ----------------------------------------------------------------------------
// positional_list_engine_unit_tb: self-checking bench for the list engine
// Drives list actions through the valid/ready input channel and checks each
// reply against a shadow copy of the list kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_tb;

  import ple_pkg::*;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned ELEM_WIDTH = 32;
  localparam int unsigned PHASE_LEN  = 142;  // random items per idling phase
  localparam int unsigned HOLD_LEN   = 300;  // long receiver hold-off, cycles
  localparam int unsigned SETTLE     = 160;  // > worst reverse/shift latency

  typedef struct {
    logic [VAL_W-1:0] rd;
    logic [LEN_W-1:0] len;
    st_e              st;
  } list_reply_t;

  // Shadow of the element store and length. Every accepted transfer updates
  // the shadow and queues the reply the block must give for it.
  class list_ledger;
    logic [ELEM_WIDTH-1:0] elems [DEPTH];
    int unsigned           count;
    list_reply_t           awaited_replies[$];
    int unsigned           errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return awaited_replies.size();
    endfunction

    function void note_action(act_e act, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
      list_reply_t           r;
      int unsigned           at;
      int unsigned           j;
      int unsigned           a;
      int unsigned           b;
      logic [ELEM_WIDTH-1:0] t;
      r.rd = '0;
      r.st = ST_OK;
      case (act)
        ACT_APPEND, ACT_PREPEND, ACT_INSERT: begin
          // range check on insert comes ahead of the full check
          if (act == ACT_INSERT && pos > count) begin
            r.st = ST_RANGE;
          end else if (count >= DEPTH) begin
            r.st = ST_FULL;
          end else begin
            at = (act == ACT_APPEND) ? count : (act == ACT_PREPEND) ? 0 : pos;
            for (j = count; j > at; j--) elems[j] = elems[j-1];
            elems[at] = val[ELEM_WIDTH-1:0];
            count++;
          end
        end
        ACT_RM_LAST: begin
          if (count == 0) r.st = ST_EMPTY;
          else count--;
        end
        ACT_RM_FIRST, ACT_RM_AT: begin
          at = (act == ACT_RM_FIRST) ? 0 : pos;
          if (count == 0) begin
            r.st = ST_EMPTY;
          end else if (at >= count) begin
            r.st = ST_RANGE;
          end else begin
            for (j = at; j + 1 < count; j++) elems[j] = elems[j+1];
            count--;
          end
        end
        ACT_REVERSE: begin
          a = 0;
          b = count;
          while (a + 1 < b) begin
            t         = elems[a];
            elems[a]  = elems[b-1];
            elems[b-1] = t;
            a++;
            b--;
          end
        end
        default: begin
          if (pos >= count) r.st = ST_RANGE;
          else r.rd = VAL_W'(elems[pos]);
        end
      endcase
      r.len = LEN_W'(count);
      awaited_replies.push_back(r);
    endfunction

    function void check_result(logic [VAL_W-1:0] rd, logic [LEN_W-1:0] len,
                               logic [ST_W-1:0] st);
      list_reply_t want;
      if (awaited_replies.size() == 0) begin
        $error("reply with no transfer outstanding: read_value %h list_length %0d status %0d",
               rd, len, st);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      if (rd !== want.rd) begin
        $error("read_value: expected %h, got %h", want.rd, rd);
        errors++;
      end
      if (len !== want.len) begin
        $error("list_length: expected %0d, got %0d", want.len, len);
        errors++;
      end
      if (st !== want.st) begin
        $error("status: expected %0d, got %0d", want.st, st);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [ACT_W-1:0] action_i    = '0;
  logic [POS_W-1:0] position_i  = '0;
  logic [VAL_W-1:0] value_i     = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [VAL_W-1:0] read_value_o;
  logic [LEN_W-1:0] list_length_o;
  logic [ST_W-1:0]  status_o;

  list_ledger  ledger = new();

  // idling percentages, changed per phase by the stimulus process
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // request from the stimulus side for one long receiver hold-off
  bit          hold_request  = 1'b0;
  // random walk direction: grow towards full, then drain towards empty
  bit          growing       = 1'b1;

  positional_list_engine_unit #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_value_o  (read_value_o),
    .list_length_o (list_length_o),
    .status_o      (status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hard stop, far beyond the slowest legal run (every item a full-length
  // shift or reverse, both sides idling at their worst).
  initial begin
    #(12 * 1_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // Output side: values read just after the edge are the ones the block
  // saw at that edge, so a transfer is valid && ready as sampled here.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        ledger.check_result(read_value_o, list_length_o, status_o);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one item; valid is only dropped during idle cycles, so a
  // back-to-back item never sees valid lowered and raised in one step.
  task automatic send_item(input act_e act, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.note_action(act, pos, val);
  endtask

  // Sender goes quiet until every outstanding reply has been taken.
  // Always advances the clock so valid is lowered in a step of its own.
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (ledger.pending() != 0);
  endtask

  // Draw a random action. The mix leans towards inserts while growing and
  // towards removes while draining, so the walk reaches both full and empty;
  // a share of positions span all 7 bits to hit the range checks.
  function automatic void draw_item(output act_e act, output logic [POS_W-1:0] pos,
                                    output logic [VAL_W-1:0] val);
    int unsigned n;
    int unsigned roll;
    n    = ledger.count;
    roll = $urandom_range(0, 99);
    if (growing) begin
      if      (roll < 30) act = ACT_APPEND;
      else if (roll < 45) act = ACT_PREPEND;
      else if (roll < 70) act = ACT_INSERT;
      else if (roll < 78) act = ACT_READ;
      else if (roll < 83) act = ACT_REVERSE;
      else if (roll < 88) act = ACT_RM_LAST;
      else if (roll < 94) act = ACT_RM_FIRST;
      else                act = ACT_RM_AT;
    end else begin
      if      (roll < 20) act = ACT_RM_LAST;
      else if (roll < 38) act = ACT_RM_FIRST;
      else if (roll < 60) act = ACT_RM_AT;
      else if (roll < 70) act = ACT_READ;
      else if (roll < 75) act = ACT_REVERSE;
      else if (roll < 83) act = ACT_APPEND;
      else if (roll < 90) act = ACT_PREPEND;
      else                act = ACT_INSERT;
    end
    if ($urandom_range(0, 99) < 15)
      pos = POS_W'($urandom_range(0, 127));
    else if (act == ACT_INSERT)
      pos = POS_W'($urandom_range(0, n));
    else
      pos = (n == 0) ? '0 : POS_W'($urandom_range(0, n - 1));
    roll = $urandom_range(0, 99);
    if      (roll < 8)  val = '0;
    else if (roll < 16) val = '1;
    else                val = $urandom;
    // linger a little at the extremes so full inserts and empty removes occur
    if (growing && n == DEPTH && $urandom_range(0, 2) == 0) growing = 1'b0;
    else if (!growing && n == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
  endfunction

  initial begin : stimulus
    act_e             act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int unsigned      phase;
    int unsigned      k;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list cases first, then a short list exercising both
    // ends, positions at and beyond the length, and reverse.
    send_item(ACT_READ,     7'd0,   32'h0);
    send_item(ACT_RM_LAST,  7'd0,   32'h0);
    send_item(ACT_RM_FIRST, 7'd0,   32'h0);
    send_item(ACT_RM_AT,    7'd0,   32'h0);
    send_item(ACT_REVERSE,  7'd0,   32'h0);
    send_item(ACT_INSERT,   7'd1,   32'h1111_1111);
    send_item(ACT_APPEND,   7'd0,   32'h0000_0000);
    send_item(ACT_REVERSE,  7'd0,   32'h0);
    send_item(ACT_APPEND,   7'd0,   32'hFFFF_FFFF);
    send_item(ACT_PREPEND,  7'd0,   32'hA5A5_A5A5);
    send_item(ACT_INSERT,   7'd0,   32'h5A5A_5A5A);
    send_item(ACT_INSERT,   7'd4,   32'h1234_5678);
    send_item(ACT_INSERT,   7'd127, 32'hDEAD_BEEF);
    send_item(ACT_READ,     7'd0,   32'h0);
    send_item(ACT_READ,     7'd4,   32'h0);
    send_item(ACT_READ,     7'd5,   32'h0);
    send_item(ACT_READ,     7'd127, 32'h0);
    send_item(ACT_REVERSE,  7'd0,   32'h0);
    send_item(ACT_READ,     7'd2,   32'h0);
    send_item(ACT_RM_AT,    7'd5,   32'h0);
    send_item(ACT_RM_AT,    7'd64,  32'h0);
    send_item(ACT_RM_AT,    7'd1,   32'h0);
    send_item(ACT_RM_FIRST, 7'd0,   32'h0);
    send_item(ACT_RM_LAST,  7'd0,   32'h0);
    send_item(ACT_READ,     7'd0,   32'h0);
    drain_replies();

    // Random: three idling phases (receiver-heavy, sender-heavy, none).
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 38; recv_idle_pct = 56; end
        1:       begin send_idle_pct = 56; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (k = 0; k < PHASE_LEN; k++) begin
        // long output stall while inputs keep coming: block backs up
        if (phase == 0 && k == 60) hold_request = 1'b1;
        // sender pause mid-phase until the block has emptied out
        if (k == 100) drain_replies();
        draw_item(act, pos, val);
        send_item(act, pos, val);
      end
      drain_replies();
    end

    repeat (SETTLE) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
